// ===== design/pbd_pkg.sv =====
package pbd_pkg;

   // result width and saturation value
   localparam int OUT_BITS = 33;
   localparam logic [OUT_BITS-1:0] OUT_MAX = {OUT_BITS{1'b1}};

   // fraction of the bezier weights and of the projection parameter
   localparam int FRAC_BITS = 16;
   localparam longint FRAC_ONE = 65536;
   localparam longint ROUND_HALF = 32768;

   // segments shorter than one unit (q.8) fall back to the far end point
   localparam longint SHORT_LIMIT = 256;

   // quotient bits of the projection divide
   localparam int DIV_STEPS = 16;

endpackage

// ===== design/pbd_req_if.sv =====
interface pbd_req_if #(
   parameter int COORD_BITS = 16
);
   logic valid;
   logic ready;
   logic signed [COORD_BITS-1:0] query_x;
   logic signed [COORD_BITS-1:0] query_y;
   logic signed [COORD_BITS-1:0] start_x;
   logic signed [COORD_BITS-1:0] start_y;
   logic signed [COORD_BITS-1:0] ctrl_a_x;
   logic signed [COORD_BITS-1:0] ctrl_a_y;
   logic signed [COORD_BITS-1:0] ctrl_b_x;
   logic signed [COORD_BITS-1:0] ctrl_b_y;
   logic signed [COORD_BITS-1:0] end_x;
   logic signed [COORD_BITS-1:0] end_y;

   modport source (
      output valid, query_x, query_y, start_x, start_y, ctrl_a_x, ctrl_a_y,
      output ctrl_b_x, ctrl_b_y, end_x, end_y,
      input ready
   );
   modport sink (
      input valid, query_x, query_y, start_x, start_y, ctrl_a_x, ctrl_a_y,
      input ctrl_b_x, ctrl_b_y, end_x, end_y,
      output ready
   );
endinterface

// ===== design/pbd_rsp_if.sv =====
interface pbd_rsp_if;
   import pbd_pkg::*;
   logic valid;
   logic ready;
   logic [OUT_BITS-1:0] min_dist_sq;

   modport source (output valid, min_dist_sq, input ready);
   modport sink (input valid, min_dist_sq, output ready);
endinterface

// ===== design/pbd_cell.sv =====
module pbd_cell #(
   parameter int COORD_BITS = 16,
   parameter int DENOM = 17,
   parameter int K = 2,
   parameter bit LAST = 1'b0
) (
   input  logic clock,
   input  logic reset,
   input  logic en,
   input  logic in_valid,
   input  logic [10*COORD_BITS-1:0] in_item,
   input  logic signed [COORD_BITS-1:0] in_px,
   input  logic signed [COORD_BITS-1:0] in_py,
   input  logic [pbd_pkg::OUT_BITS-1:0] in_best,
   output logic out_valid,
   output logic [10*COORD_BITS-1:0] out_item,
   output logic signed [COORD_BITS-1:0] out_px,
   output logic signed [COORD_BITS-1:0] out_py,
   output logic [pbd_pkg::OUT_BITS-1:0] out_best
);
   import pbd_pkg::*;

   localparam int C = COORD_BITS;
   localparam int LW = 2*C + 2;
   localparam int RB = 2*C + 3;
   localparam int MW = C + 18;
   localparam int SW = (2*C + 9 > OUT_BITS + 1) ? 2*C + 9 : OUT_BITS + 1;

   // stage numbering
   localparam int ST_WMUL = 0;
   localparam int ST_CPT = 1;
   localparam int ST_DIFF = 2;
   localparam int ST_PROD = 3;
   localparam int ST_SUM = 4;
   localparam int ST_DINIT = 5;
   localparam int ST_OMUL = ST_DINIT + DIV_STEPS + 1;
   localparam int ST_OFS = ST_OMUL + 1;
   localparam int ST_SQ = ST_OFS + 1;
   localparam int ST_FIN = ST_SQ + 1;
   localparam int NST = ST_FIN + 1;

   // bezier weights of this sample, q0.16
   localparam longint U = DENOM - K;
   localparam longint D3 = longint'(DENOM) * DENOM * DENOM;
   localparam longint W0L = (U*U*U*FRAC_ONE + D3/2) / D3;
   localparam longint W1L = (3*U*U*K*FRAC_ONE + D3/2) / D3;
   localparam longint W2L = (3*U*K*K*FRAC_ONE + D3/2) / D3;
   localparam longint W3L = (longint'(K)*K*K*FRAC_ONE + D3/2) / D3;
   localparam logic signed [17:0] W0 = 18'(W0L);
   localparam logic signed [17:0] W1 = 18'(W1L);
   localparam logic signed [17:0] W2 = 18'(W2L);
   localparam logic signed [17:0] W3 = 18'(W3L);

   localparam logic signed [C+3:0] CMAX = {5'b00000, {(C-1){1'b1}}};
   localparam logic signed [C+3:0] CMIN = {5'b11111, {(C-1){1'b0}}};

   typedef struct packed {
      logic signed [C-1:0] query_x;
      logic signed [C-1:0] query_y;
      logic signed [C-1:0] start_x;
      logic signed [C-1:0] start_y;
      logic signed [C-1:0] ctrl_a_x;
      logic signed [C-1:0] ctrl_a_y;
      logic signed [C-1:0] ctrl_b_x;
      logic signed [C-1:0] ctrl_b_y;
      logic signed [C-1:0] end_x;
      logic signed [C-1:0] end_y;
   } item_type;

   typedef struct packed {
      item_type item;
      logic signed [C-1:0] px;
      logic signed [C-1:0] py;
      logic signed [C-1:0] cx;
      logic signed [C-1:0] cy;
      logic [OUT_BITS-1:0] best;
      logic signed [C:0] tx;
      logic signed [C:0] ty;
      logic signed [C:0] dax;
      logic signed [C:0] day;
      logic signed [C:0] dbx;
      logic signed [C:0] dby;
      logic [LW-1:0] l2;
      logic [LW-1:0] sd;
      logic shrt;
      logic clz;
      logic clo;
      logic [RB-1:0] rem;
      logic [FRAC_BITS:0] q;
   } carry_type;

   logic vld_ff [NST];
   carry_type carry_ff [NST];
   carry_type carry_in [NST];

   logic signed [MW-1:0] mx_ff [4];
   logic signed [MW-1:0] my_ff [4];
   logic signed [MW-1:0] mx_in [4];
   logic signed [MW-1:0] my_in [4];
   logic signed [LW-1:0] pr_ff [6];
   logic signed [LW-1:0] pr_in [6];
   logic signed [LW:0] dot_ff, dot_in;
   logic signed [C+18:0] offx_ff, offy_ff, offx_in, offy_in;
   logic signed [C+3:0] ddx_ff, ddy_ff, ddx_in, ddy_in;
   logic signed [2*C+7:0] sqx_ff, sqy_ff, sqx_in, sqy_in;

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NST; s++) vld_ff[s] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_valid;
         for (int s = 1; s < NST; s++) vld_ff[s] <= vld_ff[s-1];
      end
   end

   // payload chain
   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s < NST; s++) carry_ff[s] <= carry_in[s];
         mx_ff <= mx_in;
         my_ff <= my_in;
         pr_ff <= pr_in;
         dot_ff <= dot_in;
         offx_ff <= offx_in;
         offy_ff <= offy_in;
         ddx_ff <= ddx_in;
         ddy_ff <= ddy_in;
         sqx_ff <= sqx_in;
         sqy_ff <= sqy_in;
      end
   end

   // weighted control points
   always_comb begin
      carry_in[ST_WMUL] = '0;
      carry_in[ST_WMUL].item = item_type'(in_item);
      carry_in[ST_WMUL].px = in_px;
      carry_in[ST_WMUL].py = in_py;
      carry_in[ST_WMUL].best = in_best;
      mx_in[0] = MW'(W0) * MW'(carry_in[ST_WMUL].item.start_x);
      mx_in[1] = MW'(W1) * MW'(carry_in[ST_WMUL].item.ctrl_a_x);
      mx_in[2] = MW'(W2) * MW'(carry_in[ST_WMUL].item.ctrl_b_x);
      mx_in[3] = MW'(W3) * MW'(carry_in[ST_WMUL].item.end_x);
      my_in[0] = MW'(W0) * MW'(carry_in[ST_WMUL].item.start_y);
      my_in[1] = MW'(W1) * MW'(carry_in[ST_WMUL].item.ctrl_a_y);
      my_in[2] = MW'(W2) * MW'(carry_in[ST_WMUL].item.ctrl_b_y);
      my_in[3] = MW'(W3) * MW'(carry_in[ST_WMUL].item.end_y);
   end

   // curve point, rounded and saturated (the end point itself in the last cell)
   always_comb begin
      logic signed [C+19:0] sx, sy;
      logic signed [C+3:0] rx, ry;
      carry_in[ST_CPT] = carry_ff[ST_WMUL];
      sx = (C+20)'(mx_ff[0]) + (C+20)'(mx_ff[1]) + (C+20)'(mx_ff[2]) + (C+20)'(mx_ff[3])
         + (C+20)'(ROUND_HALF);
      sy = (C+20)'(my_ff[0]) + (C+20)'(my_ff[1]) + (C+20)'(my_ff[2]) + (C+20)'(my_ff[3])
         + (C+20)'(ROUND_HALF);
      rx = sx[C+19:16];
      ry = sy[C+19:16];
      if (rx > CMAX) rx = CMAX;
      else if (rx < CMIN) rx = CMIN;
      if (ry > CMAX) ry = CMAX;
      else if (ry < CMIN) ry = CMIN;
      if (LAST) begin
         carry_in[ST_CPT].cx = carry_ff[ST_WMUL].item.end_x;
         carry_in[ST_CPT].cy = carry_ff[ST_WMUL].item.end_y;
      end else begin
         carry_in[ST_CPT].cx = rx[C-1:0];
         carry_in[ST_CPT].cy = ry[C-1:0];
      end
   end

   // segment direction and offsets of the query point
   always_comb begin
      carry_type c;
      c = carry_ff[ST_CPT];
      c.tx = (C+1)'(c.cx) - (C+1)'(c.px);
      c.ty = (C+1)'(c.cy) - (C+1)'(c.py);
      c.dax = (C+1)'(c.item.query_x) - (C+1)'(c.px);
      c.day = (C+1)'(c.item.query_y) - (C+1)'(c.py);
      c.dbx = (C+1)'(c.item.query_x) - (C+1)'(c.cx);
      c.dby = (C+1)'(c.item.query_y) - (C+1)'(c.cy);
      carry_in[ST_DIFF] = c;
   end

   // products for length, dot and end point distance
   always_comb begin
      carry_type c;
      c = carry_ff[ST_DIFF];
      carry_in[ST_PROD] = c;
      pr_in[0] = LW'(c.tx) * LW'(c.tx);
      pr_in[1] = LW'(c.ty) * LW'(c.ty);
      pr_in[2] = LW'(c.dax) * LW'(c.tx);
      pr_in[3] = LW'(c.day) * LW'(c.ty);
      pr_in[4] = LW'(c.dbx) * LW'(c.dbx);
      pr_in[5] = LW'(c.dby) * LW'(c.dby);
   end

   // sums
   always_comb begin
      logic signed [LW:0] l2s, sds;
      carry_in[ST_SUM] = carry_ff[ST_PROD];
      l2s = (LW+1)'(pr_ff[0]) + (LW+1)'(pr_ff[1]);
      sds = (LW+1)'(pr_ff[4]) + (LW+1)'(pr_ff[5]);
      dot_in = (LW+1)'(pr_ff[2]) + (LW+1)'(pr_ff[3]);
      carry_in[ST_SUM].l2 = l2s[LW-1:0];
      carry_in[ST_SUM].sd = sds[LW-1:0];
   end

   // clamp tests and divider seed
   always_comb begin
      carry_type c;
      c = carry_ff[ST_SUM];
      c.shrt = c.l2 < LW'(SHORT_LIMIT);
      c.clz = dot_ff[LW] || (dot_ff == '0);
      c.clo = !c.clz && (dot_ff >= $signed({1'b0, c.l2}));
      c.rem = (c.clz || c.clo) ? '0 : RB'({1'b0, dot_ff[LW-1:0]});
      c.q = '0;
      carry_in[ST_DINIT] = c;
   end

   // restoring divide, one quotient bit per stage
   for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
      always_comb begin
         carry_type c;
         logic [RB-1:0] r2;
         c = carry_ff[ST_DINIT + g];
         r2 = {c.rem[RB-2:0], 1'b0};
         if (r2 >= RB'(c.l2)) begin
            c.rem = r2 - RB'(c.l2);
            c.q = {c.q[FRAC_BITS-1:0], 1'b1};
         end else begin
            c.rem = r2;
            c.q = {c.q[FRAC_BITS-1:0], 1'b0};
         end
         carry_in[ST_DINIT + g + 1] = c;
      end
   end

   // offset along the segment
   always_comb begin
      carry_type c;
      logic [FRAC_BITS:0] qf;
      c = carry_ff[ST_OMUL - 1];
      if (c.clz) qf = '0;
      else if (c.clo) qf = (FRAC_BITS+1)'(FRAC_ONE);
      else qf = c.q;
      carry_in[ST_OMUL] = c;
      offx_in = (C+19)'(c.tx) * (C+19)'($signed({1'b0, qf}));
      offy_in = (C+19)'(c.ty) * (C+19)'($signed({1'b0, qf}));
   end

   // rounded offset and distance to the closest point
   always_comb begin
      logic signed [C+18:0] rx, ry;
      logic signed [C+2:0] ox, oy;
      carry_in[ST_OFS] = carry_ff[ST_OMUL];
      rx = offx_ff + (C+19)'(ROUND_HALF);
      ry = offy_ff + (C+19)'(ROUND_HALF);
      ox = rx[C+18:16];
      oy = ry[C+18:16];
      ddx_in = (C+4)'(carry_ff[ST_OMUL].dax) - (C+4)'(ox);
      ddy_in = (C+4)'(carry_ff[ST_OMUL].day) - (C+4)'(oy);
   end

   // squares
   always_comb begin
      carry_in[ST_SQ] = carry_ff[ST_OFS];
      sqx_in = (2*C+8)'(ddx_ff) * (2*C+8)'(ddx_ff);
      sqy_in = (2*C+8)'(ddy_ff) * (2*C+8)'(ddy_ff);
   end

   // saturate, running minimum, hand the curve point on
   always_comb begin
      carry_type c;
      logic [SW-1:0] dn, d;
      logic [OUT_BITS-1:0] ds;
      c = carry_ff[ST_SQ];
      dn = SW'(sqx_ff) + SW'(sqy_ff);
      d = c.shrt ? SW'(c.sd) : dn;
      ds = (d > SW'(OUT_MAX)) ? OUT_MAX : d[OUT_BITS-1:0];
      if (ds < c.best) c.best = ds;
      c.px = c.cx;
      c.py = c.cy;
      carry_in[ST_FIN] = c;
   end

   assign out_valid = vld_ff[ST_FIN];
   assign out_item = carry_ff[ST_FIN].item;
   assign out_px = carry_ff[ST_FIN].px;
   assign out_py = carry_ff[ST_FIN].py;
   assign out_best = carry_ff[ST_FIN].best;

endmodule

// ===== design/point_bezier_distance.sv =====
// channel   | modport | payload
// req_ch    | sink    | query, start, ctrl_a, ctrl_b, end points (signed q12.4)
// rsp_ch    | source  | min_dist_sq (unsigned q25.8)
//
// one request per cycle unless the chain is held; each of the CURVE_SAMPLES-1 segment cells
// is 26 stages, and each request passes through all cells in order.
// the 16-stage restoring divide in each cell sets the cell depth.
// reset is synchronous and clears only the valid chain.
// while a response waits unaccepted the whole chain holds and req_ch.ready is low.
module point_bezier_distance #(
   parameter int CURVE_SAMPLES = 16,
   parameter int COORD_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   pbd_req_if.sink req_ch,
   pbd_rsp_if.source rsp_ch
);
   import pbd_pkg::*;

   localparam int C = COORD_BITS;
   localparam int NC = CURVE_SAMPLES - 1;

   typedef struct packed {
      logic signed [C-1:0] query_x;
      logic signed [C-1:0] query_y;
      logic signed [C-1:0] start_x;
      logic signed [C-1:0] start_y;
      logic signed [C-1:0] ctrl_a_x;
      logic signed [C-1:0] ctrl_a_y;
      logic signed [C-1:0] ctrl_b_x;
      logic signed [C-1:0] ctrl_b_y;
      logic signed [C-1:0] end_x;
      logic signed [C-1:0] end_y;
   } item_type;

   logic en;
   item_type req_item;
   logic ch_valid [NC+1];
   logic [10*C-1:0] ch_item [NC+1];
   logic signed [C-1:0] ch_px [NC+1];
   logic signed [C-1:0] ch_py [NC+1];
   logic [OUT_BITS-1:0] ch_best [NC+1];

   // chain advances unless the final response is stuck
   assign en = !ch_valid[NC] || rsp_ch.ready;
   assign req_ch.ready = en;

   // request into the first cell
   always_comb begin
      req_item.query_x = req_ch.query_x;
      req_item.query_y = req_ch.query_y;
      req_item.start_x = req_ch.start_x;
      req_item.start_y = req_ch.start_y;
      req_item.ctrl_a_x = req_ch.ctrl_a_x;
      req_item.ctrl_a_y = req_ch.ctrl_a_y;
      req_item.ctrl_b_x = req_ch.ctrl_b_x;
      req_item.ctrl_b_y = req_ch.ctrl_b_y;
      req_item.end_x = req_ch.end_x;
      req_item.end_y = req_ch.end_y;
   end

   assign ch_valid[0] = req_ch.valid;
   assign ch_item[0] = req_item;
   assign ch_px[0] = req_ch.start_x;
   assign ch_py[0] = req_ch.start_y;
   assign ch_best[0] = OUT_MAX;

   // one cell per polyline segment
   for (genvar j = 0; j < NC; j++) begin : g_cell
      pbd_cell #(
         .COORD_BITS(C),
         .DENOM(CURVE_SAMPLES + 1),
         .K(j + 2),
         .LAST(j == NC - 1)
      ) u_cell (
         .clock(clock),
         .reset(reset),
         .en(en),
         .in_valid(ch_valid[j]),
         .in_item(ch_item[j]),
         .in_px(ch_px[j]),
         .in_py(ch_py[j]),
         .in_best(ch_best[j]),
         .out_valid(ch_valid[j+1]),
         .out_item(ch_item[j+1]),
         .out_px(ch_px[j+1]),
         .out_py(ch_py[j+1]),
         .out_best(ch_best[j+1])
      );
   end

   // response from the last cell's output register
   assign rsp_ch.valid = ch_valid[NC];
   assign rsp_ch.min_dist_sq = ch_best[NC];

endmodule
